FILE: hdl/dmc_pkg.sv
// Shared sizes, codes, types and request structs of the direct-mapped cache.
package dmc_pkg;

  localparam int LINE_BYTES = 16;
  localparam int NUM_LINES = 8;
  localparam int ADDR_BITS = 12;
  localparam int RAM_BYTES = 4096;

  localparam int OFFSET_BITS = $clog2(LINE_BYTES);
  localparam int LINE_BITS = $clog2(NUM_LINES);
  localparam int TAG_BITS = ADDR_BITS - OFFSET_BITS - LINE_BITS;
  localparam int BLOCK_BITS = ADDR_BITS - OFFSET_BITS;
  localparam int RAM_ADDR_BITS = $clog2(RAM_BYTES);
  localparam int DATA_ADDR_BITS = LINE_BITS + OFFSET_BITS;

  localparam int FIELD_ADDR_BITS = 12;
  localparam int BYTE_BITS = 8;
  localparam int COUNT_BITS = 32;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [0:0] FUNC_LOAD = 1'b0;
  localparam logic [0:0] FUNC_READ = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_HIT_COST = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MISS_COST = CFG_INDEX_BITS'(1);

  localparam logic [BYTE_BITS-1:0] HIT_COST_RESET = 8'd1;
  localparam logic [BYTE_BITS-1:0] MISS_COST_RESET = 8'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_LOOK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                      we;
    logic [DATA_ADDR_BITS-1:0] waddr;
    logic [BYTE_BITS-1:0]      wdata;
    logic [DATA_ADDR_BITS-1:0] raddr;
  } line_req_t;

  typedef struct packed {
    logic                     we;
    logic [RAM_ADDR_BITS-1:0] waddr;
    logic [BYTE_BITS-1:0]     wdata;
    logic [RAM_ADDR_BITS-1:0] raddr;
  } backing_req_t;

endpackage

FILE: hdl/dmc_backing_ram.sv
// Backing byte memory with one write port and one registered read port.
module dmc_backing_ram (
  input  logic                           clk,
  input  dmc_pkg::backing_req_t          req,
  output logic [dmc_pkg::BYTE_BITS-1:0]  rdata
);
  import dmc_pkg::*;

  logic [BYTE_BITS-1:0] mem [RAM_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

FILE: hdl/dmc_line_ram.sv
// Cache line data memory with one write port and one registered read port.
module dmc_line_ram (
  input  logic                           clk,
  input  dmc_pkg::line_req_t             req,
  output logic [dmc_pkg::BYTE_BITS-1:0]  rdata
);
  import dmc_pkg::*;

  logic [BYTE_BITS-1:0] mem [NUM_LINES * LINE_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

FILE: hdl/dmc_ctrl.sv
// Cache controller: tag store, lookup, line fill sequencer, statistics and cost registers.
module dmc_ctrl (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  func,
  input  logic [dmc_pkg::FIELD_ADDR_BITS-1:0]   address,
  input  logic [dmc_pkg::BYTE_BITS-1:0]         write_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dmc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [dmc_pkg::BYTE_BITS-1:0]         cfg_data,
  input  logic [dmc_pkg::BYTE_BITS-1:0]         backing_rdata,
  output dmc_pkg::backing_req_t                 backing_req,
  output dmc_pkg::line_req_t                    line_req,
  output logic                                  done,
  output logic                                  hit,
  output logic [dmc_pkg::BYTE_BITS-1:0]         block_number,
  output logic [dmc_pkg::COUNT_BITS-1:0]        elapsed_time,
  output logic [dmc_pkg::COUNT_BITS-1:0]        miss_total,
  output logic [dmc_pkg::COUNT_BITS-1:0]        access_total
);
  import dmc_pkg::*;

  state_t state;
  state_t state_next;

  logic [ADDR_BITS-1:0]   addr_q;
  logic                   hit_q;
  logic [OFFSET_BITS:0]   fill_cnt;
  logic [OFFSET_BITS:0]   fill_cnt_next;
  logic [NUM_LINES-1:0]   line_valid;
  logic [TAG_BITS-1:0]    line_tag [NUM_LINES];
  logic [BYTE_BITS-1:0]   hit_cost;
  logic [BYTE_BITS-1:0]   miss_cost;
  logic [COUNT_BITS-1:0]  time_count;
  logic [COUNT_BITS-1:0]  miss_count;
  logic [COUNT_BITS-1:0]  read_count;

  logic [ADDR_BITS-1:0]   in_addr;
  logic [TAG_BITS-1:0]    in_tag;
  logic [LINE_BITS-1:0]   in_line;
  logic                   lookup_hit;
  logic                   accept;
  logic                   accept_read;
  logic                   finish;
  logic [LINE_BITS-1:0]   q_line;
  logic [TAG_BITS-1:0]    q_tag;
  logic [OFFSET_BITS-1:0] q_offset;
  logic [BLOCK_BITS-1:0]  q_block;
  logic [OFFSET_BITS-1:0] fill_wr_idx;

  assign in_addr = address[ADDR_BITS-1:0];
  assign in_tag = in_addr[ADDR_BITS-1 -: TAG_BITS];
  assign in_line = in_addr[OFFSET_BITS +: LINE_BITS];
  assign lookup_hit = line_valid[in_line] && (line_tag[in_line] == in_tag);
  assign accept = start && !busy;
  assign accept_read = accept && (func == FUNC_READ);

  assign q_line = addr_q[OFFSET_BITS +: LINE_BITS];
  assign q_tag = addr_q[ADDR_BITS-1 -: TAG_BITS];
  assign q_offset = addr_q[OFFSET_BITS-1:0];
  assign q_block = addr_q[ADDR_BITS-1:OFFSET_BITS];
  assign fill_wr_idx = fill_cnt[OFFSET_BITS-1:0] - OFFSET_BITS'(1);

  assign finish = (state_next == ST_DONE) && (state != ST_DONE);

  always_comb begin
    state_next = state;
    fill_cnt_next = fill_cnt;
    case (state)
      ST_IDLE: begin
        fill_cnt_next = '0;
        if (accept_read) begin
          state_next = lookup_hit ? ST_DONE : ST_FILL;
        end
      end
      ST_FILL: begin
        fill_cnt_next = fill_cnt + (OFFSET_BITS+1)'(1);
        if (fill_cnt == (OFFSET_BITS+1)'(LINE_BYTES)) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy = 1'b1;
    done = 1'b0;
    backing_req.we = accept && (func == FUNC_LOAD);
    backing_req.waddr = RAM_ADDR_BITS'(in_addr);
    backing_req.wdata = write_data;
    backing_req.raddr = RAM_ADDR_BITS'({q_block, fill_cnt[OFFSET_BITS-1:0]});
    line_req.we = 1'b0;
    line_req.waddr = {q_line, fill_wr_idx};
    line_req.wdata = backing_rdata;
    line_req.raddr = {q_line, q_offset};
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        line_req.raddr = {in_line, in_addr[OFFSET_BITS-1:0]};
      end
      ST_FILL: begin
        line_req.we = (fill_cnt != '0);
      end
      ST_LOOK: begin
      end
      ST_DONE: begin
        done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign cfg_ready = 1'b1;
  assign hit = hit_q;
  assign block_number = BYTE_BITS'(q_block);
  assign elapsed_time = time_count;
  assign miss_total = miss_count;
  assign access_total = read_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill_cnt <= '0;
      line_valid <= '0;
      hit_cost <= HIT_COST_RESET;
      miss_cost <= MISS_COST_RESET;
      time_count <= '0;
      miss_count <= '0;
      read_count <= '0;
    end else begin
      state <= state_next;
      fill_cnt <= fill_cnt_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HIT_COST: hit_cost <= cfg_data;
          CFG_MISS_COST: miss_cost <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == ST_FILL && fill_cnt == '0) begin
        line_valid[q_line] <= 1'b1;
      end
      if (finish) begin
        read_count <= read_count + COUNT_BITS'(1);
        if (hit_q || (state == ST_IDLE)) begin
          time_count <= time_count + COUNT_BITS'(hit_cost);
        end else begin
          time_count <= time_count + COUNT_BITS'(miss_cost);
          miss_count <= miss_count + COUNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_read) begin
      addr_q <= in_addr;
      hit_q <= lookup_hit;
    end
    if (state == ST_FILL && fill_cnt == '0) begin
      line_tag[q_line] <= q_tag;
    end
  end

endmodule

FILE: hdl/direct_mapped_cache_read.sv
// Top level of the read-only direct-mapped cache with its backing memory.
// A load word (func 0) writes one backing byte and is taken with no result;
// the next word may follow in the next cycle. A read word (func 1) gives
// exactly one result, shown for one cycle with result_valid high, and the
// receiver cannot stall it. A hit goes from acceptance directly to ST_DONE,
// where the result is shown; a miss first runs the line fill (ST_FILL) that
// copies one byte per cycle through the single read port of the backing memory
// and then reads the line memory (ST_LOOK) before ST_DONE. Cost registers may
// be written at any time the block is idle; cfg_ready is always high.
module direct_mapped_cache_read (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 func,
  input  logic [dmc_pkg::FIELD_ADDR_BITS-1:0]  address,
  input  logic [dmc_pkg::BYTE_BITS-1:0]        write_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dmc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [dmc_pkg::BYTE_BITS-1:0]        cfg_data,
  output logic                                 result_valid,
  output logic [dmc_pkg::BYTE_BITS-1:0]        read_data,
  output logic                                 hit,
  output logic [dmc_pkg::BYTE_BITS-1:0]        block_number,
  output logic [dmc_pkg::COUNT_BITS-1:0]       elapsed_time,
  output logic [dmc_pkg::COUNT_BITS-1:0]       miss_total,
  output logic [dmc_pkg::COUNT_BITS-1:0]       access_total
);
  import dmc_pkg::*;

  backing_req_t         backing_req;
  line_req_t            line_req;
  logic [BYTE_BITS-1:0] backing_rdata;

  dmc_backing_ram u_backing (
    .clk   (clk),
    .req   (backing_req),
    .rdata (backing_rdata)
  );

  dmc_line_ram u_lines (
    .clk   (clk),
    .req   (line_req),
    .rdata (read_data)
  );

  dmc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .address       (address),
    .write_data    (write_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .backing_rdata (backing_rdata),
    .backing_req   (backing_req),
    .line_req      (line_req),
    .done          (result_valid),
    .hit           (hit),
    .block_number  (block_number),
    .elapsed_time  (elapsed_time),
    .miss_total    (miss_total),
    .access_total  (access_total)
  );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the direct-mapped read cache with predicted results per read.
module testbench;
  import dmc_pkg::*;

  localparam int ITEM_TARGET = 650;
  localparam int SETTLE_CYCLES = 30;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [BYTE_BITS-1:0]  read_data;
    logic                  hit;
    logic [BYTE_BITS-1:0]  block_number;
    logic [COUNT_BITS-1:0] elapsed_time;
    logic [COUNT_BITS-1:0] miss_total;
    logic [COUNT_BITS-1:0] access_total;
  } read_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic func = 1'b0;
  logic [FIELD_ADDR_BITS-1:0] address = '0;
  logic [BYTE_BITS-1:0] write_data = '0;
  logic cfg_valid = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [BYTE_BITS-1:0] cfg_data = '0;
  logic busy;
  logic cfg_ready;
  logic result_valid;
  logic [BYTE_BITS-1:0] read_data;
  logic hit;
  logic [BYTE_BITS-1:0] block_number;
  logic [COUNT_BITS-1:0] elapsed_time;
  logic [COUNT_BITS-1:0] miss_total;
  logic [COUNT_BITS-1:0] access_total;

  logic [BYTE_BITS-1:0] hit_cost = HIT_COST_RESET;
  logic [BYTE_BITS-1:0] miss_cost = MISS_COST_RESET;
  logic cache_valid [NUM_LINES] = '{default: 1'b0};
  logic [TAG_BITS-1:0] cache_tag [NUM_LINES] = '{default: '0};
  logic [BYTE_BITS-1:0] cache_bytes [NUM_LINES*LINE_BYTES] = '{default: 8'h23};
  logic [BYTE_BITS-1:0] backing_bytes [RAM_BYTES];
  logic loaded [RAM_BYTES] = '{default: 1'b0};
  int block_fill [1<<BLOCK_BITS] = '{default: 0};
  logic [BLOCK_BITS-1:0] full_blocks [$];
  logic [COUNT_BITS-1:0] time_total = '0;
  logic [COUNT_BITS-1:0] miss_count = '0;
  logic [COUNT_BITS-1:0] read_count = '0;

  read_result_t expected_reads [$];
  int items_sent = 0;
  int loads_sent = 0;
  int hits_seen = 0;
  int cost_settings = 0;
  int errors = 0;
  int quiet_cycles = 0;
  bit sender_pauses = 1'b1;

  direct_mapped_cache_read u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .address(address),
    .write_data(write_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .result_valid(result_valid),
    .read_data(read_data), .hit(hit), .block_number(block_number),
    .elapsed_time(elapsed_time), .miss_total(miss_total), .access_total(access_total)
  );

  always #10 clk = ~clk;

  function automatic read_result_t cache_lookup(input logic [FIELD_ADDR_BITS-1:0] a);
    read_result_t r;
    logic [OFFSET_BITS-1:0] off;
    logic [BLOCK_BITS-1:0] blk;
    logic [LINE_BITS-1:0] ln;
    logic [TAG_BITS-1:0] tg;
    int i;
    off = a[OFFSET_BITS-1:0];
    blk = a[ADDR_BITS-1:OFFSET_BITS];
    ln = blk[LINE_BITS-1:0];
    tg = blk[BLOCK_BITS-1:LINE_BITS];
    r.hit = cache_valid[ln] && cache_tag[ln] == tg;
    if (r.hit) begin
      time_total += COUNT_BITS'(hit_cost);
      hits_seen++;
    end else begin
      miss_count += 1;
      time_total += COUNT_BITS'(miss_cost);
      for (i = 0; i < LINE_BYTES; i++) begin
        cache_bytes[{ln, OFFSET_BITS'(i)}] = backing_bytes[{blk, OFFSET_BITS'(i)}];
      end
      cache_tag[ln] = tg;
      cache_valid[ln] = 1'b1;
    end
    read_count += 1;
    r.read_data = cache_bytes[{ln, off}];
    r.block_number = BYTE_BITS'(blk);
    r.elapsed_time = time_total;
    r.miss_total = miss_count;
    r.access_total = read_count;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [COUNT_BITS-1:0] want,
                               input logic [COUNT_BITS-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    read_result_t want;
    if (!rst && result_valid) begin
      if (expected_reads.size() == 0) begin
        $display("%0t: result with no read outstanding, read_data %0h", $time, read_data);
        errors++;
      end else begin
        want = expected_reads.pop_front();
        compare_field("read_data", COUNT_BITS'(want.read_data), COUNT_BITS'(read_data));
        compare_field("hit", COUNT_BITS'(want.hit), COUNT_BITS'(hit));
        compare_field("block_number", COUNT_BITS'(want.block_number),
                      COUNT_BITS'(block_number));
        compare_field("elapsed_time", want.elapsed_time, elapsed_time);
        compare_field("miss_total", want.miss_total, miss_total);
        compare_field("access_total", want.access_total, access_total);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("direct_mapped_cache_read: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic f, input logic [FIELD_ADDR_BITS-1:0] a,
                           input logic [BYTE_BITS-1:0] d);
    int gap;
    gap = sender_pauses ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    address <= a;
    write_data <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (f == FUNC_READ) begin
      expected_reads.push_back(cache_lookup(a));
    end else begin
      backing_bytes[a] = d;
      loads_sent++;
      if (!loaded[a]) begin
        loaded[a] = 1'b1;
        block_fill[a[ADDR_BITS-1:OFFSET_BITS]]++;
        if (block_fill[a[ADDR_BITS-1:OFFSET_BITS]] == LINE_BYTES) begin
          full_blocks.push_back(a[ADDR_BITS-1:OFFSET_BITS]);
        end
      end
    end
    items_sent++;
  endtask

  task automatic wait_until_quiet();
    start <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_costs(input logic [BYTE_BITS-1:0] h, input logic [BYTE_BITS-1:0] m);
    wait_until_quiet();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_HIT_COST;
    cfg_data <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    hit_cost = h;
    cfg_index <= CFG_MISS_COST;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    miss_cost = m;
    cfg_valid <= 1'b0;
    cost_settings++;
  endtask

  // A read is only issued to a line already holding its block or to a block
  // whose sixteen backing bytes have all been loaded.
  task automatic run_traffic(input int count);
    int stop_at;
    int pick;
    int base;
    int i;
    logic [BLOCK_BITS-1:0] blk;
    logic [LINE_BITS-1:0] ln;
    logic [OFFSET_BITS-1:0] off;
    stop_at = items_sent + count;
    sender_pauses = ($urandom_range(0, 3) != 0);
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      off = OFFSET_BITS'($urandom);
      if (pick < 10) begin
        blk = BLOCK_BITS'($urandom);
        base = $urandom_range(0, LINE_BYTES - 1);
        for (i = 0; i < LINE_BYTES; i++) begin
          send_word(FUNC_LOAD, {blk, OFFSET_BITS'(base + i)}, BYTE_BITS'($urandom));
        end
      end else if (pick < 17) begin
        send_word(FUNC_LOAD, FIELD_ADDR_BITS'($urandom), BYTE_BITS'($urandom));
      end else if (pick < 55) begin
        ln = LINE_BITS'($urandom);
        if (cache_valid[ln]) begin
          send_word(FUNC_READ, {cache_tag[ln], ln, off}, BYTE_BITS'($urandom));
        end
      end else begin
        blk = full_blocks[$urandom_range(0, full_blocks.size() - 1)];
        send_word(FUNC_READ, {blk, off}, BYTE_BITS'($urandom));
      end
    end
  endtask

  // Reset costs, first miss and hit at the top of the address space, and a
  // hit that returns the old byte after the backing memory was reloaded.
  task automatic test_first_access();
    int i;
    send_word(FUNC_LOAD, '0, 8'hFF);
    for (i = 0; i < LINE_BYTES; i++) begin
      send_word(FUNC_LOAD, {8'hFF, OFFSET_BITS'(i)}, BYTE_BITS'(i * 8'h11));
    end
    send_word(FUNC_READ, 12'hFFF, 8'h00);
    send_word(FUNC_READ, 12'hFF0, 8'hFF);
    send_word(FUNC_LOAD, 12'hFF5, 8'h5A);
    send_word(FUNC_READ, 12'hFF5, 8'h00);
  endtask

  task automatic test_cost_extremes();
    set_costs(8'h00, 8'h00);
    run_traffic(30);
    set_costs(8'hFF, 8'hFF);
    run_traffic(30);
    set_costs(8'h00, 8'hFF);
    run_traffic(30);
    set_costs(8'hFF, 8'h00);
    run_traffic(30);
  endtask

  task automatic test_random_traffic();
    while (items_sent < ITEM_TARGET) begin
      set_costs(BYTE_BITS'($urandom), BYTE_BITS'($urandom));
      run_traffic(80);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_first_access();
    test_cost_extremes();
    test_random_traffic();
    wait_until_quiet();
    $display("Covered %0d loads and %0d reads (%0d hits, %0d misses) under %0d cost settings.",
             loads_sent, read_count, hits_seen, miss_count, cost_settings + 1);
    if (errors == 0) begin
      $display("direct_mapped_cache_read: match");
    end else begin
      $display("direct_mapped_cache_read: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/dmc_pkg.sv
hdl/dmc_backing_ram.sv
hdl/dmc_line_ram.sv
hdl/dmc_ctrl.sv
hdl/direct_mapped_cache_read.sv
verif/testbench.sv
